@@ rtl/i2cee_pkg.sv @@
// Package for the I2C EEPROM master: phase and command codes, item structs.
// No dependencies; used by every module of the block.
package i2cee_pkg;

    typedef enum logic [4:0] {
        PH_IDLE, PH_STA, PH_STB, PH_STC, PH_RCL, PH_RCH,
        PH_DWL, PH_DWH, PH_WAL, PH_WAH, PH_DRL, PH_DRH,
        PH_WDL, PH_WDH, PH_RXL, PH_RXH, PH_SPA, PH_SPB,
        PH_SPC, PH_WAIT
    } phase_t;

    typedef enum logic [2:0] {
        CMD_TICK, CMD_LOAD, CMD_WRITE, CMD_READ, CMD_RECOVER
    } cmd_kind_t;

    localparam logic [2:0] FUNC_TICK    = 3'd0;
    localparam logic [2:0] FUNC_LOAD    = 3'd1;
    localparam logic [2:0] FUNC_WRITE   = 3'd2;
    localparam logic [2:0] FUNC_READ    = 3'd3;
    localparam logic [2:0] FUNC_RECOVER = 3'd4;

    // start and stop kinds, held in the bit counter
    localparam logic [3:0] START_FIRST    = 4'd0;
    localparam logic [3:0] START_RESTART  = 4'd1;
    localparam logic [3:0] START_RECOVER  = 4'd2;
    localparam logic [3:0] START_RECOVER2 = 4'd3;
    localparam logic [3:0] STOP_PLAIN     = 4'd0;
    localparam logic [3:0] STOP_ERROR     = 4'd1;
    localparam logic [3:0] STOP_WRITE     = 4'd2;

    localparam logic [3:0] RECOVERY_CLOCKS = 4'd9;

    localparam logic [1:0] REG_DEVICE_CODE = 2'd0;
    localparam logic [1:0] REG_ACK_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_WRITE_WAIT  = 2'd2;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        sda_in;
        logic        page;
        logic [7:0]  word_addr;
        logic [4:0]  length;
        logic [3:0]  buf_index;
        logic [7:0]  data_byte;
    } cmd_t;

    typedef struct packed {
        logic [5:0]  device_code;
        logic [7:0]  ack_timeout;
        logic [15:0] write_wait_ticks;
    } cfg_t;

    typedef struct packed {
        logic        scl;
        logic        sda_out;
        logic        sda_oe;
        logic        busy_res;
        logic        read_valid;
        logic [7:0]  read_data;
        logic        read_last;
        logic        done_res;
        logic        error;
    } res_t;

    typedef struct packed {
        logic valid;
    } q_ctrl_t;

endpackage

@@ rtl/i2c_eeprom_master.sv @@
// Top level of the I2C EEPROM master: stream ports, APB registers, assertions.
// Depends on i2cee_pkg, i2cee_front, i2cee_queue and i2cee_back.
//
// Each input transaction is one bus phase tick (or, while idle, a command in
// tuser: 0 tick, 1 load write-buffer byte, 2 sequential write, 3 random
// sequential read, 4 bus recovery) and yields exactly one result transaction
// with the SCL/SDA levels to drive for that phase plus status. The block takes
// one transaction per clock while m_tready is high: the front end decodes into
// a two-entry queue and the sequencer retires one entry per clock into the
// output register, so the single-step phase sequencer sets the rate. An item
// goes through a queue slot, then the output register. There is no clearing pass after reset.
// Registers: 0x0 device_code, 0x4 ack_timeout, 0x8 write_wait_ticks; write
// them only while the bus is idle.
module i2c_eeprom_master #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sda_in[0], page[1], word_addr[9:2], length[14:10], buf_index[18:15],
    // data_byte[26:19], zero fill [31:27]
    input  logic [31:0] s_tdata,
    // func[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // scl[0], sda_out[1], sda_oe[2], busy_res[3], read_valid[4],
    // read_data[12:5], done_res[13], error[14], zero fill [15]
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    i2cee_pkg::cfg_t     cfg_reg;
    i2cee_pkg::cmd_t     front_cmd, head_cmd;
    i2cee_pkg::q_ctrl_t  q_ctrl;
    i2cee_pkg::res_t     res;
    logic                q_full, pop, push;
    logic [1:0]          q_count;

    assign pready   = 1'b1;
    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    // register writes on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_code      <= 6'd40;
            cfg_reg.ack_timeout      <= 8'd250;
            cfg_reg.write_wait_ticks <= 16'd10000;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                i2cee_pkg::REG_DEVICE_CODE: cfg_reg.device_code      <= pwdata[5:0];
                i2cee_pkg::REG_ACK_TIMEOUT: cfg_reg.ack_timeout      <= pwdata[7:0];
                i2cee_pkg::REG_WRITE_WAIT:  cfg_reg.write_wait_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            i2cee_pkg::REG_DEVICE_CODE: prdata = {26'd0, cfg_reg.device_code};
            i2cee_pkg::REG_ACK_TIMEOUT: prdata = {24'd0, cfg_reg.ack_timeout};
            i2cee_pkg::REG_WRITE_WAIT:  prdata = {16'd0, cfg_reg.write_wait_ticks};
            default:                    prdata = 32'd0;
        endcase
    end

    i2cee_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
        .func   (s_tuser),
        .fields (s_tdata[26:0]),
        .cmd    (front_cmd)
    );

    i2cee_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (front_cmd),
        .full       (q_full),
        .ctrl_valid (q_ctrl),
        .pop        (pop),
        .head_cmd   (head_cmd),
        .count      (q_count)
    );

    i2cee_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_in    (q_ctrl),
        .cmd     (head_cmd),
        .pop     (pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .res     (res)
    );

    assign m_tdata = {1'b0, res.error, res.done_res, res.read_data, res.read_valid,
                      res.busy_res, res.sda_oe, res.sda_out, res.scl};
    assign m_tlast = res.read_last;

    // error only comes with the end of a transaction
    a_err_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.error |-> res.done_res)
        else $error("error without done");

    // a read byte flag or done never shows on an idle bus phase
    a_rv_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res.read_valid || res.done_res) |-> res.busy_res)
        else $error("read or done outside a transaction");

    // idle phases drive both lines high
    a_idle_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !res.busy_res |-> res.scl && res.sda_out && res.sda_oe)
        else $error("idle bus not high");

    // queue never overfills and pops only what it holds
    a_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count != 2'd3 && (!pop || q_count != 2'd0))
        else $error("queue count out of range");
endmodule

@@ rtl/i2cee_front.sv @@
// Front end: unpack the input transaction and classify it into a command.
// Depends on i2cee_pkg.
module i2cee_front #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic [2:0]       func,
    input  logic [26:0]      fields,
    output i2cee_pkg::cmd_t  cmd
);
    logic [4:0] len_in;

    assign len_in = fields[14:10];

    always_comb begin
        cmd.sda_in    = fields[0];
        cmd.page      = fields[1];
        cmd.word_addr = fields[9:2];
        cmd.length    = len_in;
        cmd.buf_index = fields[18:15];
        cmd.data_byte = fields[26:19];
        case (func)
            i2cee_pkg::FUNC_LOAD:    cmd.kind = i2cee_pkg::CMD_LOAD;
            i2cee_pkg::FUNC_WRITE: begin
                cmd.kind = i2cee_pkg::CMD_WRITE;
                // clamp write length to the buffer
                if ({2'b00, len_in} > 7'(BUFFER_DEPTH))
                    cmd.length = 5'(BUFFER_DEPTH);
            end
            i2cee_pkg::FUNC_READ:    cmd.kind = i2cee_pkg::CMD_READ;
            i2cee_pkg::FUNC_RECOVER: cmd.kind = i2cee_pkg::CMD_RECOVER;
            default:                 cmd.kind = i2cee_pkg::CMD_TICK;
        endcase
    end
endmodule

@@ rtl/i2cee_queue.sv @@
// Two-entry command queue between front and back ends.
// Depends on i2cee_pkg.
module i2cee_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  i2cee_pkg::cmd_t     push_cmd,
    output logic                full,
    output i2cee_pkg::q_ctrl_t  ctrl_valid,
    input  logic                pop,
    output i2cee_pkg::cmd_t     head_cmd,
    output logic [1:0]          count
);
    i2cee_pkg::cmd_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full             = (count_reg == 2'd2);
    assign ctrl_valid.valid = (count_reg != 2'd0);
    assign head_cmd         = slot_reg[rd_ptr_reg];
    assign count            = count_reg;

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_cmd;
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ rtl/i2cee_back.sv @@
// Back end: bus phase sequencer, write buffer and result register.
// Depends on i2cee_pkg.
module i2cee_back #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  i2cee_pkg::cfg_t     cfg,
    input  i2cee_pkg::q_ctrl_t  q_in,
    input  i2cee_pkg::cmd_t     cmd,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output i2cee_pkg::res_t     res
);
    localparam int IW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic [7:0] buf_mem [BUFFER_DEPTH];

    i2cee_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  bit_reg, bit_next;
    logic [4:0]  byte_reg, byte_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  tmo_reg, tmo_next;
    logic [15:0] wait_reg, wait_next;
    logic [7:0]  addr_reg, addr_next;
    logic        page_reg, page_next;
    logic [4:0]  len_reg, len_next;
    logic        rd_reg, rd_next;
    logic        valid_reg;
    i2cee_pkg::res_t res_reg, r;

    i2cee_pkg::phase_t ph;
    logic          buf_we;
    logic [IW-1:0] buf_rd_addr;
    logic [7:0]    buf_word;
    logic [4:0]    byte_inc;
    logic [3:0]    bit_inc;
    logic          last_byte;
    logic [7:0]    rx_byte;

    assign pop      = q_in.valid && (!valid_reg || m_ready);
    assign m_valid  = valid_reg;
    assign res      = res_reg;
    assign byte_inc = byte_reg + 5'd1;
    assign bit_inc  = bit_reg + 4'd1;
    assign last_byte = ({1'b0, byte_reg} + 6'd1) >= {1'b0, len_reg};
    assign rx_byte  = {shift_reg[6:0], cmd.sda_in};

    // one read port: slot zero after the address byte, else the next slot
    assign buf_rd_addr = (phase_reg == i2cee_pkg::PH_WAH) ? '0 : IW'(byte_inc);
    assign buf_word    = buf_mem[buf_rd_addr];

    always_comb begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        shift_next = shift_reg;
        tmo_next   = tmo_reg;
        wait_next  = wait_reg;
        addr_next  = addr_reg;
        page_next  = page_reg;
        len_next   = len_reg;
        rd_next    = rd_reg;
        buf_we     = 1'b0;
        r          = '0;
        r.scl      = 1'b1;
        r.sda_out  = 1'b1;
        r.sda_oe   = 1'b1;
        ph         = phase_reg;

        if (phase_reg == i2cee_pkg::PH_IDLE) begin
            case (cmd.kind)
                i2cee_pkg::CMD_LOAD: begin
                    buf_we = ({3'b000, cmd.buf_index} < 7'(BUFFER_DEPTH));
                end
                i2cee_pkg::CMD_WRITE, i2cee_pkg::CMD_READ: begin
                    addr_next = cmd.word_addr;
                    page_next = cmd.page;
                    len_next  = cmd.length;
                    rd_next   = (cmd.kind == i2cee_pkg::CMD_READ);
                    bit_next  = i2cee_pkg::START_FIRST;
                    ph        = i2cee_pkg::PH_STA;
                end
                i2cee_pkg::CMD_RECOVER: begin
                    bit_next = i2cee_pkg::START_RECOVER;
                    ph       = i2cee_pkg::PH_STA;
                end
                default: ;
            endcase
        end

        r.busy_res = (ph != i2cee_pkg::PH_IDLE);

        case (ph)
            i2cee_pkg::PH_STA: phase_next = i2cee_pkg::PH_STB;
            i2cee_pkg::PH_STB: begin
                r.sda_out  = 1'b0;
                phase_next = i2cee_pkg::PH_STC;
            end
            i2cee_pkg::PH_STC: begin
                r.scl     = 1'b0;
                r.sda_out = 1'b0;
                if (bit_reg == i2cee_pkg::START_RESTART) begin
                    shift_next = {cfg.device_code, page_reg, 1'b1};
                    bit_next   = 4'd0;
                    phase_next = i2cee_pkg::PH_DRL;
                end else if (bit_reg == i2cee_pkg::START_RECOVER) begin
                    bit_next   = 4'd0;
                    phase_next = i2cee_pkg::PH_RCL;
                end else if (bit_reg == i2cee_pkg::START_RECOVER2) begin
                    bit_next   = i2cee_pkg::STOP_PLAIN;
                    phase_next = i2cee_pkg::PH_SPA;
                end else begin
                    shift_next = {cfg.device_code, page_reg, 1'b0};
                    bit_next   = 4'd0;
                    phase_next = i2cee_pkg::PH_DWL;
                end
            end
            i2cee_pkg::PH_RCL: begin
                r.scl      = 1'b0;
                phase_next = i2cee_pkg::PH_RCH;
            end
            i2cee_pkg::PH_RCH: begin
                if (bit_inc >= i2cee_pkg::RECOVERY_CLOCKS) begin
                    bit_next   = i2cee_pkg::START_RECOVER2;
                    phase_next = i2cee_pkg::PH_STA;
                end else begin
                    bit_next   = bit_inc;
                    phase_next = i2cee_pkg::PH_RCL;
                end
            end
            i2cee_pkg::PH_DWL, i2cee_pkg::PH_WAL,
            i2cee_pkg::PH_DRL, i2cee_pkg::PH_WDL: begin
                r.scl = 1'b0;
                if (bit_reg < 4'd8) begin
                    r.sda_out = shift_reg[7];
                end else begin
                    r.sda_oe = 1'b0;
                    tmo_next = 8'd0;
                end
                phase_next = i2cee_pkg::phase_t'(5'(ph) + 5'd1);
            end
            i2cee_pkg::PH_DWH, i2cee_pkg::PH_WAH,
            i2cee_pkg::PH_DRH, i2cee_pkg::PH_WDH: begin
                if (bit_reg < 4'd8) begin
                    r.sda_out  = shift_reg[7];
                    shift_next = {shift_reg[6:0], 1'b0};
                    bit_next   = bit_inc;
                    phase_next = i2cee_pkg::phase_t'(5'(ph) - 5'd1);
                end else begin
                    r.sda_oe = 1'b0;
                    if (!cmd.sda_in) begin
                        bit_next = 4'd0;
                        case (ph)
                            i2cee_pkg::PH_DWH: begin
                                shift_next = addr_reg;
                                phase_next = i2cee_pkg::PH_WAL;
                            end
                            i2cee_pkg::PH_WAH: begin
                                byte_next = 5'd0;
                                if (rd_reg) begin
                                    bit_next   = i2cee_pkg::START_RESTART;
                                    phase_next = i2cee_pkg::PH_STA;
                                end else if (len_reg == 5'd0) begin
                                    bit_next   = i2cee_pkg::STOP_WRITE;
                                    phase_next = i2cee_pkg::PH_SPA;
                                end else begin
                                    shift_next = buf_word;
                                    phase_next = i2cee_pkg::PH_WDL;
                                end
                            end
                            i2cee_pkg::PH_WDH: begin
                                byte_next = byte_inc;
                                if (byte_inc >= len_reg) begin
                                    bit_next   = i2cee_pkg::STOP_WRITE;
                                    phase_next = i2cee_pkg::PH_SPA;
                                end else begin
                                    shift_next = buf_word;
                                    phase_next = i2cee_pkg::PH_WDL;
                                end
                            end
                            default: begin
                                byte_next = 5'd0;
                                if (len_reg == 5'd0) begin
                                    bit_next   = i2cee_pkg::STOP_PLAIN;
                                    phase_next = i2cee_pkg::PH_SPA;
                                end else begin
                                    shift_next = 8'd0;
                                    phase_next = i2cee_pkg::PH_RXL;
                                end
                            end
                        endcase
                    end else if (tmo_reg >= cfg.ack_timeout) begin
                        bit_next   = i2cee_pkg::STOP_ERROR;
                        phase_next = i2cee_pkg::PH_SPA;
                    end else begin
                        tmo_next = tmo_reg + 8'd1;
                    end
                end
            end
            i2cee_pkg::PH_RXL: begin
                r.scl = 1'b0;
                if (bit_reg < 4'd8) r.sda_oe  = 1'b0;
                else                r.sda_out = last_byte;
                phase_next = i2cee_pkg::PH_RXH;
            end
            i2cee_pkg::PH_RXH: begin
                if (bit_reg < 4'd8) begin
                    r.sda_oe   = 1'b0;
                    shift_next = rx_byte;
                    bit_next   = bit_inc;
                    if (bit_inc == 4'd8) begin
                        r.read_valid = 1'b1;
                        r.read_data  = rx_byte;
                        r.read_last  = last_byte;
                    end
                    phase_next = i2cee_pkg::PH_RXL;
                end else begin
                    r.sda_out = last_byte;
                    byte_next = byte_inc;
                    bit_next  = 4'd0;
                    if (byte_inc >= len_reg) begin
                        bit_next   = i2cee_pkg::STOP_PLAIN;
                        phase_next = i2cee_pkg::PH_SPA;
                    end else begin
                        shift_next = 8'd0;
                        phase_next = i2cee_pkg::PH_RXL;
                    end
                end
            end
            i2cee_pkg::PH_SPA: begin
                r.scl      = 1'b0;
                r.sda_out  = 1'b0;
                phase_next = i2cee_pkg::PH_SPB;
            end
            i2cee_pkg::PH_SPB: begin
                r.sda_out  = 1'b0;
                phase_next = i2cee_pkg::PH_SPC;
            end
            i2cee_pkg::PH_SPC: begin
                if (bit_reg == i2cee_pkg::STOP_WRITE && cfg.write_wait_ticks != 16'd0) begin
                    wait_next  = cfg.write_wait_ticks;
                    phase_next = i2cee_pkg::PH_WAIT;
                end else begin
                    r.done_res = 1'b1;
                    r.error    = (bit_reg == i2cee_pkg::STOP_ERROR);
                    phase_next = i2cee_pkg::PH_IDLE;
                end
                bit_next = 4'd0;
            end
            i2cee_pkg::PH_WAIT: begin
                if (wait_reg != 16'd0) wait_next = wait_reg - 16'd1;
                if (wait_reg <= 16'd1) begin
                    r.done_res = 1'b1;
                    phase_next = i2cee_pkg::PH_IDLE;
                end
            end
            default: phase_next = i2cee_pkg::PH_IDLE;
        endcase

        if (!r.sda_oe) r.sda_out = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (pop && buf_we) buf_mem[IW'(cmd.buf_index)] <= cmd.data_byte;
        if (pop) res_reg <= r;
        if (!aresetn) begin
            phase_reg <= i2cee_pkg::PH_IDLE;
            bit_reg   <= 4'd0;
            byte_reg  <= 5'd0;
            shift_reg <= 8'd0;
            tmo_reg   <= 8'd0;
            wait_reg  <= 16'd0;
            addr_reg  <= 8'd0;
            page_reg  <= 1'b0;
            len_reg   <= 5'd0;
            rd_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg <= phase_next;
                bit_reg   <= bit_next;
                byte_reg  <= byte_next;
                shift_reg <= shift_next;
                tmo_reg   <= tmo_next;
                wait_reg  <= wait_next;
                addr_reg  <= addr_next;
                page_reg  <= page_next;
                len_reg   <= len_next;
                rd_reg    <= rd_next;
            end
            if (pop)          valid_reg <= 1'b1;
            else if (m_ready) valid_reg <= 1'b0;
        end
    end
endmodule

@@ test/tb_top.sv @@
// Testbench for the I2C EEPROM master: drives phase ticks and commands on the
// input stream, predicts every result transaction and checks it field by field.
// Depends on i2cee_pkg and the i2c_eeprom_master RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int N_RANDOM   = 450;
    localparam int WATCH_MAX  = 4000;
    localparam int DEPTH      = 16;

    // one input transaction: func in tuser, the rest packed in tdata
    typedef struct {
        logic [2:0] func;
        logic       sda_in;
        logic       page;
        logic [7:0] word_addr;
        logic [4:0] length;
        logic [3:0] buf_index;
        logic [7:0] data_byte;
    } tick_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    i2c_eeprom_master dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ---------------- predictor state ----------------
    logic [5:0]  p_devcode;
    logic [7:0]  p_acktmo;
    logic [15:0] p_wwait;
    i2cee_pkg::phase_t p_phase;
    logic [3:0]  p_bits;
    logic [4:0]  p_bytes;
    logic [7:0]  p_shift;
    logic [7:0]  p_tmo;
    logic [15:0] p_wcnt;
    logic [14:0] p_cmd;
    logic [7:0]  p_wbuf [DEPTH];

    i2cee_pkg::res_t bus_expected [$];
    tick_t pending [$];
    int   errors = 0;
    int   n_results = 0, n_reads = 0, n_done = 0, n_err = 0;

    function automatic logic [7:0] dev_byte(input logic rw);
        return {p_devcode, p_cmd[8], rw};
    endfunction

    task automatic enter_stop(input logic [3:0] kind);
        p_bits  = kind;
        p_phase = i2cee_pkg::PH_SPA;
    endtask

    // next phase once a sent byte has been acknowledged
    task automatic acked(input i2cee_pkg::phase_t ph);
        p_bits = 0;
        if (ph == i2cee_pkg::PH_DWH) begin
            p_shift = p_cmd[7:0];
            p_phase = i2cee_pkg::PH_WAL;
        end else if (ph == i2cee_pkg::PH_WAH) begin
            p_bytes = 0;
            if (p_cmd[14]) begin
                p_bits  = i2cee_pkg::START_RESTART;
                p_phase = i2cee_pkg::PH_STA;
            end else if (p_cmd[13:9] == 0) begin
                enter_stop(i2cee_pkg::STOP_WRITE);
            end else begin
                p_shift = p_wbuf[0];
                p_phase = i2cee_pkg::PH_WDL;
            end
        end else if (ph == i2cee_pkg::PH_WDH) begin
            p_bytes = p_bytes + 5'd1;
            if (p_bytes >= p_cmd[13:9]) begin
                enter_stop(i2cee_pkg::STOP_WRITE);
            end else begin
                p_shift = p_wbuf[p_bytes[3:0]];
                p_phase = i2cee_pkg::PH_WDL;
            end
        end else begin
            p_bytes = 0;
            if (p_cmd[13:9] == 0) begin
                enter_stop(i2cee_pkg::STOP_PLAIN);
            end else begin
                p_shift = 0;
                p_phase = i2cee_pkg::PH_RXL;
            end
        end
    endtask

    // advance the sequencer by one tick and return the bus levels and status
    task automatic predict_tick(input tick_t t, output i2cee_pkg::res_t r);
        i2cee_pkg::phase_t ph;
        logic [4:0] len;
        logic       lastb;
        r = '0;
        r.scl = 1; r.sda_out = 1; r.sda_oe = 1;
        len = t.length;
        if (p_phase == i2cee_pkg::PH_IDLE) begin
            if (t.func == i2cee_pkg::FUNC_LOAD) begin
                p_wbuf[t.buf_index] = t.data_byte;
            end else if (t.func == i2cee_pkg::FUNC_WRITE || t.func == i2cee_pkg::FUNC_READ) begin
                if (t.func == i2cee_pkg::FUNC_WRITE && len > DEPTH) len = 5'(DEPTH);
                p_cmd   = {t.func == i2cee_pkg::FUNC_READ, len, t.page, t.word_addr};
                p_bits  = i2cee_pkg::START_FIRST;
                p_phase = i2cee_pkg::PH_STA;
            end else if (t.func == i2cee_pkg::FUNC_RECOVER) begin
                p_bits  = i2cee_pkg::START_RECOVER;
                p_phase = i2cee_pkg::PH_STA;
            end
        end
        ph = p_phase;
        r.busy_res = (ph != i2cee_pkg::PH_IDLE);
        lastb = ({1'b0, p_bytes} + 6'd1) >= {1'b0, p_cmd[13:9]};
        case (ph)
            i2cee_pkg::PH_STA: p_phase = i2cee_pkg::PH_STB;
            i2cee_pkg::PH_STB: begin
                r.sda_out = 0;
                p_phase = i2cee_pkg::PH_STC;
            end
            i2cee_pkg::PH_STC: begin
                r.scl = 0; r.sda_out = 0;
                if (p_bits == i2cee_pkg::START_RESTART) begin
                    p_shift = dev_byte(1'b1); p_bits = 0; p_phase = i2cee_pkg::PH_DRL;
                end else if (p_bits == i2cee_pkg::START_RECOVER) begin
                    p_bits = 0; p_phase = i2cee_pkg::PH_RCL;
                end else if (p_bits == i2cee_pkg::START_RECOVER2) begin
                    enter_stop(i2cee_pkg::STOP_PLAIN);
                end else begin
                    p_shift = dev_byte(1'b0); p_bits = 0; p_phase = i2cee_pkg::PH_DWL;
                end
            end
            i2cee_pkg::PH_RCL: begin
                r.scl = 0;
                p_phase = i2cee_pkg::PH_RCH;
            end
            i2cee_pkg::PH_RCH: begin
                p_bits = p_bits + 4'd1;
                if (p_bits >= i2cee_pkg::RECOVERY_CLOCKS) begin
                    p_bits = i2cee_pkg::START_RECOVER2; p_phase = i2cee_pkg::PH_STA;
                end else begin
                    p_phase = i2cee_pkg::PH_RCL;
                end
            end
            i2cee_pkg::PH_DWL, i2cee_pkg::PH_WAL, i2cee_pkg::PH_DRL, i2cee_pkg::PH_WDL: begin
                r.scl = 0;
                if (p_bits < 8) begin
                    r.sda_out = p_shift[7];
                end else begin
                    r.sda_oe = 0;
                    p_tmo = 0;
                end
                p_phase = i2cee_pkg::phase_t'(5'(ph) + 5'd1);
            end
            i2cee_pkg::PH_DWH, i2cee_pkg::PH_WAH, i2cee_pkg::PH_DRH, i2cee_pkg::PH_WDH: begin
                if (p_bits < 8) begin
                    r.sda_out = p_shift[7];
                    p_shift = p_shift << 1;
                    p_bits = p_bits + 4'd1;
                    p_phase = i2cee_pkg::phase_t'(5'(ph) - 5'd1);
                end else begin
                    r.sda_oe = 0;
                    if (!t.sda_in) acked(ph);
                    else if (p_tmo >= p_acktmo) enter_stop(i2cee_pkg::STOP_ERROR);
                    else p_tmo = p_tmo + 8'd1;
                end
            end
            i2cee_pkg::PH_RXL: begin
                r.scl = 0;
                if (p_bits < 8) r.sda_oe = 0;
                else r.sda_out = lastb;
                p_phase = i2cee_pkg::PH_RXH;
            end
            i2cee_pkg::PH_RXH: begin
                if (p_bits < 8) begin
                    r.sda_oe = 0;
                    p_shift = {p_shift[6:0], t.sda_in};
                    p_bits = p_bits + 4'd1;
                    if (p_bits == 8) begin
                        r.read_valid = 1;
                        r.read_data = p_shift;
                        r.read_last = lastb;
                    end
                    p_phase = i2cee_pkg::PH_RXL;
                end else begin
                    r.sda_out = lastb;
                    p_bytes = p_bytes + 5'd1;
                    p_bits = 0;
                    if (p_bytes >= p_cmd[13:9]) begin
                        enter_stop(i2cee_pkg::STOP_PLAIN);
                    end else begin
                        p_shift = 0;
                        p_phase = i2cee_pkg::PH_RXL;
                    end
                end
            end
            i2cee_pkg::PH_SPA: begin
                r.scl = 0; r.sda_out = 0;
                p_phase = i2cee_pkg::PH_SPB;
            end
            i2cee_pkg::PH_SPB: begin
                r.sda_out = 0;
                p_phase = i2cee_pkg::PH_SPC;
            end
            i2cee_pkg::PH_SPC: begin
                if (p_bits == i2cee_pkg::STOP_WRITE && p_wwait != 0) begin
                    p_wcnt = p_wwait;
                    p_phase = i2cee_pkg::PH_WAIT;
                end else begin
                    r.done_res = 1;
                    r.error = (p_bits == i2cee_pkg::STOP_ERROR);
                    p_phase = i2cee_pkg::PH_IDLE;
                end
                p_bits = 0;
            end
            i2cee_pkg::PH_WAIT: begin
                if (p_wcnt != 0) p_wcnt = p_wcnt - 16'd1;
                if (p_wcnt == 0) begin
                    r.done_res = 1;
                    p_phase = i2cee_pkg::PH_IDLE;
                end
            end
            default: p_phase = i2cee_pkg::PH_IDLE;
        endcase
        if (!r.sda_oe) r.sda_out = 1;
    endtask

    // ---------------- stimulus helpers ----------------
    // the generator runs its own copy of the phase so that it knows when the
    // block is idle; it simply tracks the predictor one step ahead of the dut

    function automatic tick_t plain_tick(input logic sda);
        tick_t t;
        t = '{default: '0};
        t.func = i2cee_pkg::FUNC_TICK;
        t.sda_in = sda;
        t.word_addr = 8'($urandom); t.length = 5'($urandom); t.buf_index = 4'($urandom);
        t.data_byte = 8'($urandom); t.page = 1'($urandom);
        return t;
    endfunction

    function automatic tick_t load_tick(input logic [3:0] idx, input logic [7:0] d);
        tick_t t;
        t = plain_tick(1'($urandom));
        t.func = i2cee_pkg::FUNC_LOAD; t.buf_index = idx; t.data_byte = d;
        return t;
    endfunction

    function automatic tick_t cmd_tick(input logic [2:0] f, input logic pg,
                                       input logic [7:0] a, input logic [4:0] n);
        tick_t t;
        t = plain_tick(1'($urandom));
        t.func = f; t.page = pg; t.word_addr = a; t.length = n;
        return t;
    endfunction

    // a command occupies the bus until done; feed ticks whose SDA level fits
    // a cooperative device (ack low) except with the given chance of a nack
    // run, and stop once the shadow predictor is back in idle
    i2cee_pkg::phase_t sh_phase;
    int          gen_count = 0;

    task automatic push(input tick_t t);
        pending.push_back(t);
        gen_count++;
    endtask

    // shadow copy of the sequencer used only to shape stimulus
    i2cee_pkg::res_t sh_r;
    task automatic shadow_run(input tick_t cmd, input int nack_pct);
        tick_t t;
        int    guard;
        push(cmd);
        shadow_step(cmd);
        guard = 0;
        while (sh_phase != i2cee_pkg::PH_IDLE && guard < 200000) begin
            t = plain_tick($urandom_range(99, 0) < nack_pct ? 1'b1 : 1'b0);
            if ($urandom_range(3, 0) == 0) t.func = 3'($urandom);   // ignored while busy
            if (sh_phase == i2cee_pkg::PH_RXH) t.sda_in = 1'($urandom);
            push(t);
            shadow_step(t);
            guard++;
        end
    endtask

    // shadow state mirrors the predictor's variables
    logic [5:0]  s_dc; logic [7:0] s_at; logic [15:0] s_ww;
    logic [3:0]  s_bits; logic [4:0] s_bytes; logic [7:0] s_shift, s_tmo;
    logic [15:0] s_wcnt; logic [14:0] s_cmd; logic [7:0] s_wbuf [DEPTH];

    task automatic swap_state();
        i2cee_pkg::phase_t ph; logic [5:0] dc; logic [7:0] at; logic [15:0] ww;
        logic [3:0] b; logic [4:0] by; logic [7:0] sh, tm; logic [15:0] wc;
        logic [14:0] c;
        ph = p_phase; p_phase = sh_phase; sh_phase = ph;
        dc = p_devcode; p_devcode = s_dc; s_dc = dc;
        at = p_acktmo; p_acktmo = s_at; s_at = at;
        ww = p_wwait; p_wwait = s_ww; s_ww = ww;
        b = p_bits; p_bits = s_bits; s_bits = b;
        by = p_bytes; p_bytes = s_bytes; s_bytes = by;
        sh = p_shift; p_shift = s_shift; s_shift = sh;
        tm = p_tmo; p_tmo = s_tmo; s_tmo = tm;
        wc = p_wcnt; p_wcnt = s_wcnt; s_wcnt = wc;
        c = p_cmd; p_cmd = s_cmd; s_cmd = c;
        for (int i = 0; i < DEPTH; i++) begin
            sh = p_wbuf[i]; p_wbuf[i] = s_wbuf[i]; s_wbuf[i] = sh;
        end
    endtask

    task automatic shadow_step(input tick_t t);
        swap_state();
        predict_tick(t, sh_r);
        swap_state();
    endtask

    // ---------------- driver ----------------
    logic feed_on = 1'b0;
    logic idle_on = 1'b1;
    logic in_taken = 1'b0;
    int   gap_in = 0;
    int   gap_out = 0;
    int   sent = 0;

    always @(negedge aclk) begin
        if (aresetn) begin
            // hold the current transaction until it is taken
            if (s_tvalid && !in_taken) begin
            end else if (gap_in > 0) begin
                gap_in <= gap_in - 1;
                s_tvalid <= 1'b0;
            end else if (feed_on && pending.size() > 0) begin
                tick_t t;
                t = pending.pop_front();
                s_tuser  <= t.func;
                s_tdata  <= {5'd0, t.data_byte, t.buf_index, t.length,
                             t.word_addr, t.page, t.sda_in};
                s_tvalid <= 1'b1;
                if (idle_on && $urandom_range(9, 0) == 0) gap_in <= $urandom_range(14, 1);
            end else begin
                s_tvalid <= 1'b0;
            end
            // receiver stalls in bursts
            if (gap_out > 0) begin
                gap_out <= gap_out - 1;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(11, 0) == 0) begin
                gap_out <= $urandom_range(14, 1);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------- monitor ----------------
    int   idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                tick_t t;
                i2cee_pkg::res_t r;
                t.func = s_tuser;
                {t.data_byte, t.buf_index, t.length, t.word_addr, t.page, t.sda_in}
                    = s_tdata[26:0];
                predict_tick(t, r);
                bus_expected.push_back(r);
                sent++;
            end
            if (m_tvalid && m_tready) begin
                i2cee_pkg::res_t got, want;
                got.scl = m_tdata[0]; got.sda_out = m_tdata[1]; got.sda_oe = m_tdata[2];
                got.busy_res = m_tdata[3]; got.read_valid = m_tdata[4];
                got.read_data = m_tdata[12:5]; got.done_res = m_tdata[13];
                got.error = m_tdata[14]; got.read_last = m_tlast;
                n_results++;
                if (bus_expected.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, got);
                    errors++;
                end else begin
                    want = bus_expected.pop_front();
                    if (got.read_valid) n_reads++;
                    if (got.done_res) n_done++;
                    if (got.error) n_err++;
                    if (got.scl !== want.scl || got.sda_out !== want.sda_out ||
                        got.sda_oe !== want.sda_oe || got.busy_res !== want.busy_res ||
                        got.read_valid !== want.read_valid ||
                        got.read_data !== want.read_data ||
                        got.read_last !== want.read_last ||
                        got.done_res !== want.done_res || got.error !== want.error) begin
                        $display("%0t: result mismatch, expected %h actual %h",
                                 $time, want, got);
                        errors++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCH_MAX) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ---------------- configuration ----------------
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            i2cee_pkg::REG_DEVICE_CODE: begin p_devcode = val[5:0];  s_dc = val[5:0];  end
            i2cee_pkg::REG_ACK_TIMEOUT: begin p_acktmo  = val[7:0];  s_at = val[7:0];  end
            default:                    begin p_wwait   = val[15:0]; s_ww = val[15:0]; end
        endcase
    endtask

    // release the queued items and wait until the block has drained
    task automatic drain();
        feed_on = 1'b1;
        wait (pending.size() == 0 && !s_tvalid && bus_expected.size() == 0);
        feed_on = 1'b0;
        repeat (4) @(posedge aclk);
    endtask

    task automatic random_phase(input int n_items);
        int stop_at;
        stop_at = gen_count + n_items;
        while (gen_count < stop_at) begin
            int k;
            k = $urandom_range(99, 0);
            if (k < 25) begin
                push(load_tick(4'($urandom), 8'($urandom)));
                shadow_step(pending[$]);
            end else if (k < 50) begin
                int n;
                n = ($urandom_range(9, 0) == 0) ? $urandom_range(31, 17) : $urandom_range(4, 0);
                // only send slots that hold data: load first if needed
                for (int i = 0; i < DEPTH && i < n; i++) begin
                    push(load_tick(4'(i), 8'($urandom)));
                    shadow_step(pending[$]);
                end
                shadow_run(cmd_tick(i2cee_pkg::FUNC_WRITE, 1'($urandom), 8'($urandom), 5'(n)),
                           $urandom_range(2, 0) == 0 ? 40 : 3);
            end else if (k < 80) begin
                shadow_run(cmd_tick(i2cee_pkg::FUNC_READ, 1'($urandom), 8'($urandom),
                                    ($urandom_range(9, 0) == 0) ? 5'($urandom)
                                                                : 5'($urandom_range(3, 0))),
                           $urandom_range(2, 0) == 0 ? 40 : 3);
            end else if (k < 88) begin
                shadow_run(cmd_tick(i2cee_pkg::FUNC_RECOVER, 1'($urandom), 8'($urandom),
                                    5'($urandom)), 0);
            end else begin
                tick_t t;
                t = plain_tick(1'($urandom));
                t.func = 3'($urandom_range(7, 5)) ^ ($urandom_range(1, 0) ? 3'd0 : 3'd5);
                push(t);
                shadow_step(t);
            end
        end
    endtask

    initial begin
        p_devcode = 6'd40; p_acktmo = 8'd250; p_wwait = 16'd10000;
        p_phase = i2cee_pkg::PH_IDLE; p_bits = 0; p_bytes = 0; p_shift = 0; p_tmo = 0;
        p_wcnt = 0; p_cmd = 0;
        s_dc = 6'd40; s_at = 8'd250; s_ww = 16'd10000;
        sh_phase = i2cee_pkg::PH_IDLE; s_bits = 0; s_bytes = 0; s_shift = 0; s_tmo = 0;
        s_wcnt = 0; s_cmd = 0;
        for (int i = 0; i < DEPTH; i++) begin
            p_wbuf[i] = 0; s_wbuf[i] = 0;
        end
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: short write wait, tight ack timeout, extreme device codes
        reg_write(i2cee_pkg::REG_WRITE_WAIT, 32'd3);
        reg_write(i2cee_pkg::REG_ACK_TIMEOUT, 32'd2);
        reg_write(i2cee_pkg::REG_DEVICE_CODE, 32'd63);
        for (int i = 0; i < DEPTH; i++) begin
            push(load_tick(4'(i), i[0] ? 8'hFF : 8'h00));
            shadow_step(pending[$]);
        end
        push(load_tick(4'd15, 8'hA5)); shadow_step(pending[$]);
        shadow_run(cmd_tick(i2cee_pkg::FUNC_WRITE, 1'b1, 8'hFF, 5'd31), 0);   // saturating length
        shadow_run(cmd_tick(i2cee_pkg::FUNC_WRITE, 1'b0, 8'h00, 5'd0), 0);    // no data bytes
        shadow_run(cmd_tick(i2cee_pkg::FUNC_READ, 1'b1, 8'h80, 5'd0), 0);     // read of nothing
        shadow_run(cmd_tick(i2cee_pkg::FUNC_READ, 1'b0, 8'h01, 5'd2), 0);
        shadow_run(cmd_tick(i2cee_pkg::FUNC_READ, 1'b0, 8'h7F, 5'd1), 100);   // missing ack
        shadow_run(cmd_tick(i2cee_pkg::FUNC_RECOVER, 1'b0, 8'h00, 5'd0), 0);
        drain();

        // zero timeout and zero write wait
        reg_write(i2cee_pkg::REG_ACK_TIMEOUT, 32'd0);
        reg_write(i2cee_pkg::REG_WRITE_WAIT, 32'd0);
        reg_write(i2cee_pkg::REG_DEVICE_CODE, 32'd0);
        shadow_run(cmd_tick(i2cee_pkg::FUNC_WRITE, 1'b1, 8'h55, 5'd2), 0);
        shadow_run(cmd_tick(i2cee_pkg::FUNC_READ, 1'b1, 8'hAA, 5'd1), 100);
        drain();

        // phases over several register settings, random traffic after the first, last one with no idling
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    reg_write(i2cee_pkg::REG_ACK_TIMEOUT, 32'd255);
                    reg_write(i2cee_pkg::REG_WRITE_WAIT, 32'd120);
                    reg_write(i2cee_pkg::REG_DEVICE_CODE, $urandom);
                    // one long wait only: keep this phase short
                    shadow_run(cmd_tick(i2cee_pkg::FUNC_WRITE, 1'b0, 8'h10, 5'd1), 0);
                end
                1: begin
                    reg_write(i2cee_pkg::REG_ACK_TIMEOUT, $urandom_range(8, 1));
                    reg_write(i2cee_pkg::REG_WRITE_WAIT, $urandom_range(20, 0));
                    reg_write(i2cee_pkg::REG_DEVICE_CODE, $urandom);
                    random_phase(N_RANDOM / 3);
                end
                2: begin
                    reg_write(i2cee_pkg::REG_ACK_TIMEOUT, 32'd1);
                    reg_write(i2cee_pkg::REG_WRITE_WAIT, 32'd1);
                    random_phase(N_RANDOM / 3);
                end
                default: begin
                    reg_write(i2cee_pkg::REG_ACK_TIMEOUT, $urandom_range(20, 0));
                    reg_write(i2cee_pkg::REG_WRITE_WAIT, $urandom_range(50, 0));
                    idle_on = 1'b0;
                    random_phase(N_RANDOM / 3);
                end
            endcase
            drain();
        end
        repeat (8) @(posedge aclk);

        $display("Checked %0d result transactions: %0d read bytes, %0d finished",
                 n_results, n_reads, n_done);
        $display("transfers, %0d of them aborted on a missing acknowledge.", n_err);
        if (errors == 0 && bus_expected.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
